// ===== hw/rtl/crcanv_pkg.sv =====
// shared types, codes and defaults for the circle raster canvas
package crcanv_pkg;

    // default sizes
    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;
    localparam int DEF_FRAC_BITS  = 8;

    // fixed field widths
    localparam int OP_W     = 2;
    localparam int CHAR_W   = 8;
    localparam int CENTER_W = 18;
    localparam int RADIUS_W = 17;
    localparam int RC_W     = 8;
    localparam int SIZE_W   = 9;
    localparam int MUL_W    = 18;
    localparam int RSQ_W    = 2 * MUL_W;

    localparam int IN_TDATA_W  = 88;
    localparam int OUT_TDATA_W = 16;

    // command codes
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [OP_W-1:0] OP_DRAW  = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    // shape bytes
    localparam logic [CHAR_W-1:0] SHAPE_DISC    = 8'h43;
    localparam logic [CHAR_W-1:0] SHAPE_OUTLINE = 8'h63;

    // register indexes
    localparam logic [1:0] REG_CANVAS_WIDTH  = 2'd0;
    localparam logic [1:0] REG_CANVAS_HEIGHT = 2'd1;
    localparam logic [1:0] REG_BACKGROUND    = 2'd2;

    localparam logic [SIZE_W-1:0] RST_CANVAS_WIDTH  = 9'd256;
    localparam logic [SIZE_W-1:0] RST_CANVAS_HEIGHT = 9'd256;
    localparam logic [CHAR_W-1:0] RST_BACKGROUND    = 8'd32;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_CX,
        ST_MUL_CY,
        ST_MUL_R,
        ST_MUL_RI,
        ST_SCAN,
        ST_READ,
        ST_DONE
    } ctrl_state_t;

    typedef enum logic [1:0] {
        MUL_CX,
        MUL_CY,
        MUL_R,
        MUL_RI
    } mul_sel_t;

    typedef struct packed {
        logic     load;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     scan_step;
        logic     read_en;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic draw_ok;
        logic last_cell;
        logic out_free;
    } stat_t;

endpackage

// ===== hw/rtl/crcanv_ctrl.sv =====
// command sequencer for the circle raster canvas
module crcanv_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [crcanv_pkg::OP_W-1:0] in_op,
    input  crcanv_pkg::stat_t           stat,
    output logic                        in_ready,
    output crcanv_pkg::cmd_t            cmd
);

    crcanv_pkg::ctrl_state_t state_reg;
    crcanv_pkg::ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= crcanv_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            crcanv_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (in_op)
                        crcanv_pkg::OP_CLEAR: state_next = crcanv_pkg::ST_SCAN;
                        crcanv_pkg::OP_DRAW:  state_next = crcanv_pkg::ST_MUL_CX;
                        crcanv_pkg::OP_READ:  state_next = crcanv_pkg::ST_READ;
                        default:              state_next = crcanv_pkg::ST_DONE;
                    endcase
                end
            end
            crcanv_pkg::ST_MUL_CX: state_next = crcanv_pkg::ST_MUL_CY;
            crcanv_pkg::ST_MUL_CY: state_next = crcanv_pkg::ST_MUL_R;
            crcanv_pkg::ST_MUL_R:  state_next = crcanv_pkg::ST_MUL_RI;
            crcanv_pkg::ST_MUL_RI:
            begin
                // rejected draws skip the scan and leave the canvas alone
                state_next = stat.draw_ok ? crcanv_pkg::ST_SCAN : crcanv_pkg::ST_DONE;
            end
            crcanv_pkg::ST_SCAN:
            begin
                if (stat.last_cell)
                begin
                    state_next = crcanv_pkg::ST_DONE;
                end
            end
            crcanv_pkg::ST_READ: state_next = crcanv_pkg::ST_DONE;
            crcanv_pkg::ST_DONE:
            begin
                if (stat.out_free)
                begin
                    state_next = crcanv_pkg::ST_IDLE;
                end
            end
            default: state_next = crcanv_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready      = 1'b0;
        cmd.load      = 1'b0;
        cmd.mul_en    = 1'b0;
        cmd.mul_sel   = crcanv_pkg::MUL_CX;
        cmd.scan_step = 1'b0;
        cmd.read_en   = 1'b0;
        cmd.out_load  = 1'b0;
        unique case (state_reg)
            crcanv_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            crcanv_pkg::ST_MUL_CX:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = crcanv_pkg::MUL_CX;
            end
            crcanv_pkg::ST_MUL_CY:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = crcanv_pkg::MUL_CY;
            end
            crcanv_pkg::ST_MUL_R:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = crcanv_pkg::MUL_R;
            end
            crcanv_pkg::ST_MUL_RI:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = crcanv_pkg::MUL_RI;
            end
            crcanv_pkg::ST_SCAN: cmd.scan_step = 1'b1;
            crcanv_pkg::ST_READ: cmd.read_en   = 1'b1;
            crcanv_pkg::ST_DONE: cmd.out_load  = stat.out_free;
            default: ;
        endcase
    end

endmodule

// ===== hw/rtl/crcanv_datapath.sv =====
// canvas memory, distance tracking and result register
module crcanv_datapath #(
    parameter int MAX_WIDTH  = crcanv_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = crcanv_pkg::DEF_MAX_HEIGHT,
    parameter int FRAC_BITS  = crcanv_pkg::DEF_FRAC_BITS,
    parameter int W_W        = $clog2(MAX_WIDTH + 1),
    parameter int H_W        = $clog2(MAX_HEIGHT + 1)
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  crcanv_pkg::cmd_t                         cmd,
    output crcanv_pkg::stat_t                        stat,
    input  logic [crcanv_pkg::OP_W-1:0]              in_op,
    input  logic [crcanv_pkg::CHAR_W-1:0]            in_shape,
    input  logic signed [crcanv_pkg::CENTER_W-1:0]   in_cx,
    input  logic signed [crcanv_pkg::CENTER_W-1:0]   in_cy,
    input  logic [crcanv_pkg::RADIUS_W-1:0]          in_radius,
    input  logic [crcanv_pkg::CHAR_W-1:0]            in_paint,
    input  logic [crcanv_pkg::RC_W-1:0]              in_col,
    input  logic [crcanv_pkg::RC_W-1:0]              in_row,
    input  logic [crcanv_pkg::CHAR_W-1:0]            bg_char,
    input  logic [W_W-1:0]                           w_used,
    input  logic [H_W-1:0]                           h_used,
    output logic                                     out_valid,
    input  logic                                     out_ready,
    output logic                                     out_status,
    output logic [crcanv_pkg::CHAR_W-1:0]            out_cell
);

    localparam int X_W     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int Y_W     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COORD_W = (X_W > Y_W) ? X_W : Y_W;
    localparam int POS_W   = COORD_W + FRAC_BITS + 1;
    localparam int D_W     = ((POS_W > crcanv_pkg::CENTER_W) ? POS_W : crcanv_pkg::CENTER_W) + 2;
    localparam int SQ_W    = 2 * D_W;
    localparam int MUL_W   = crcanv_pkg::MUL_W;

    localparam logic signed [D_W-1:0] ONE_D  = D_W'(1) << FRAC_BITS;
    localparam logic [SQ_W-1:0]       ONE_SQ = SQ_W'(1) << (2 * FRAC_BITS);
    localparam logic [MUL_W-1:0]      ONE_R  = MUL_W'(1) << FRAC_BITS;

    // captured command
    logic [crcanv_pkg::OP_W-1:0]            op_reg;
    logic [crcanv_pkg::CHAR_W-1:0]          shape_reg;
    logic signed [crcanv_pkg::CENTER_W-1:0] cx_reg;
    logic signed [crcanv_pkg::CENTER_W-1:0] cy_reg;
    logic [crcanv_pkg::RADIUS_W-1:0]        radius_reg;
    logic [crcanv_pkg::CHAR_W-1:0]          paint_reg;
    logic [crcanv_pkg::RC_W-1:0]            col_reg;
    logic [crcanv_pkg::RC_W-1:0]            row_reg;

    // squared bounds
    logic [SQ_W-1:0]              cx2_reg;
    logic [crcanv_pkg::RSQ_W-1:0] outer_reg;
    logic [crcanv_pkg::RSQ_W-1:0] inner_reg;

    // scan position and running squared offsets
    logic [X_W-1:0]           x_reg, x_next;
    logic [Y_W-1:0]           y_reg, y_next;
    logic [ADDR_W-1:0]        row_base_reg, row_base_next;
    logic signed [D_W-1:0]    dx_reg, dx_next;
    logic signed [D_W-1:0]    dy_reg, dy_next;
    logic [SQ_W-1:0]          dx2_reg, dx2_next;
    logic [SQ_W-1:0]          dy2_reg, dy2_next;

    logic [crcanv_pkg::CHAR_W-1:0] mem [DEPTH];
    logic [crcanv_pkg::CHAR_W-1:0] rd_data_reg;

    logic                          out_valid_reg;
    logic                          out_status_reg;
    logic [crcanv_pkg::CHAR_W-1:0] out_cell_reg;

    logic [MUL_W-1:0]              cx_mag;
    logic [MUL_W-1:0]              cy_mag;
    logic [MUL_W-1:0]              r_ext;
    logic [MUL_W-1:0]              r_less_one;
    logic [MUL_W-1:0]              mul_a;
    logic [crcanv_pkg::RSQ_W-1:0]  prod;

    logic                          is_clear;
    logic                          outline;
    logic                          inner_any;
    logic                          draw_ok;
    logic                          x_last;
    logic                          y_last;
    logic [SQ_W:0]                 d2;
    logic                          hit;
    logic [ADDR_W-1:0]             scan_addr;
    logic [31:0]                   rd_lin;
    logic [ADDR_W-1:0]             rd_addr;
    logic                          rd_in_range;
    logic signed [SQ_W-1:0]        dx_ext;
    logic signed [SQ_W-1:0]        dy_ext;
    logic [SQ_W-1:0]               step_x;
    logic [SQ_W-1:0]               step_y;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= in_op;
            shape_reg  <= in_shape;
            cx_reg     <= in_cx;
            cy_reg     <= in_cy;
            radius_reg <= in_radius;
            paint_reg  <= in_paint;
            col_reg    <= in_col;
            row_reg    <= in_row;
        end
    end

    assign cx_mag     = cx_reg[crcanv_pkg::CENTER_W-1] ? MUL_W'(-cx_reg) : MUL_W'(cx_reg);
    assign cy_mag     = cy_reg[crcanv_pkg::CENTER_W-1] ? MUL_W'(-cy_reg) : MUL_W'(cy_reg);
    assign r_ext      = MUL_W'(radius_reg);
    assign inner_any  = (r_ext >= ONE_R);
    assign r_less_one = inner_any ? (r_ext - ONE_R) : '0;

    // one shared squarer, stepped through the setup states
    always_comb
    begin
        case (cmd.mul_sel)
            crcanv_pkg::MUL_CX: mul_a = cx_mag;
            crcanv_pkg::MUL_CY: mul_a = cy_mag;
            crcanv_pkg::MUL_R:  mul_a = r_ext;
            default:            mul_a = r_less_one;
        endcase
    end

    assign prod = mul_a * mul_a;

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            case (cmd.mul_sel)
                crcanv_pkg::MUL_CX: cx2_reg   <= SQ_W'(prod);
                crcanv_pkg::MUL_R:  outer_reg <= prod;
                crcanv_pkg::MUL_RI: inner_reg <= prod;
                default: ;
            endcase
        end
    end

    assign is_clear = (op_reg == crcanv_pkg::OP_CLEAR);
    assign outline  = (shape_reg == crcanv_pkg::SHAPE_OUTLINE);
    assign draw_ok  = (radius_reg != '0)
                    && ((shape_reg == crcanv_pkg::SHAPE_DISC) || outline);

    assign x_last = ((W_W'(x_reg) + W_W'(1)) == w_used);
    assign y_last = ((H_W'(y_reg) + H_W'(1)) == h_used);

    assign d2  = {1'b0, dy2_reg} + {1'b0, dx2_reg};
    assign hit = is_clear
               || ((d2 <= (SQ_W + 1)'(outer_reg))
                   && !(outline && inner_any && (d2 <= (SQ_W + 1)'(inner_reg))));

    // (d + one)^2 = d^2 + 2*one*d + one^2
    assign dx_ext = SQ_W'(dx_reg);
    assign dy_ext = SQ_W'(dy_reg);
    assign step_x = SQ_W'(dx_ext <<< (FRAC_BITS + 1)) + ONE_SQ;
    assign step_y = SQ_W'(dy_ext <<< (FRAC_BITS + 1)) + ONE_SQ;

    always_comb
    begin
        x_next        = x_reg;
        y_next        = y_reg;
        row_base_next = row_base_reg;
        dx_next       = dx_reg;
        dy_next       = dy_reg;
        dx2_next      = dx2_reg;
        dy2_next      = dy2_reg;
        if (cmd.load)
        begin
            x_next        = '0;
            y_next        = '0;
            row_base_next = '0;
            dx_next       = -D_W'(in_cx);
            dy_next       = -D_W'(in_cy);
        end
        else if (cmd.mul_en)
        begin
            case (cmd.mul_sel)
                crcanv_pkg::MUL_CX: dx2_next = SQ_W'(prod);
                crcanv_pkg::MUL_CY: dy2_next = SQ_W'(prod);
                default: ;
            endcase
        end
        else if (cmd.scan_step)
        begin
            if (x_last)
            begin
                x_next        = '0;
                y_next        = y_reg + Y_W'(1);
                row_base_next = row_base_reg + ADDR_W'(MAX_WIDTH);
                dx_next       = -D_W'(cx_reg);
                dx2_next      = cx2_reg;
                dy_next       = dy_reg + ONE_D;
                dy2_next      = dy2_reg + step_y;
            end
            else
            begin
                x_next   = x_reg + X_W'(1);
                dx_next  = dx_reg + ONE_D;
                dx2_next = dx2_reg + step_x;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        y_reg        <= y_next;
        row_base_reg <= row_base_next;
        dx_reg       <= dx_next;
        dy_reg       <= dy_next;
        dx2_reg      <= dx2_next;
        dy2_reg      <= dy2_next;
    end

    assign scan_addr = row_base_reg + ADDR_W'(x_reg);

    assign rd_in_range = (32'(col_reg) < 32'(w_used)) && (32'(row_reg) < 32'(h_used));
    assign rd_lin      = 32'(row_reg) * 32'(MAX_WIDTH) + 32'(col_reg);
    assign rd_addr     = rd_lin[ADDR_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.scan_step && hit)
        begin
            mem[scan_addr] <= is_clear ? bg_char : paint_reg;
        end
        if (cmd.read_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // result register: frees the sequencer while the beat waits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_status_reg <= (op_reg == crcanv_pkg::OP_DRAW) && !draw_ok;
            out_cell_reg   <= ((op_reg == crcanv_pkg::OP_READ) && rd_in_range)
                              ? rd_data_reg : '0;
        end
    end

    assign stat.draw_ok   = draw_ok;
    assign stat.last_cell = x_last && y_last;
    assign stat.out_free  = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_cell   = out_cell_reg;

endmodule

// ===== hw/rtl/circle_raster_canvas_core.sv =====
// top level of the circle raster canvas: config registers, sequencer and datapath
//
//  port group   dir  payload
//  s_t*         in   tuser: op; tdata: shape, cx, cy, radius, paint, col, row
//  m_t*         out  tdata: status, cell_value
//  cfg_*        in   write enable, register index, data
//
// each command is accepted in idle, then: clear scans the cells in use; draw squares
// cx, cy, r and r-1, then scans (a rejected draw skips the scan); read reads one cell;
// an unused op goes straight to done; the scan writes one cell a cycle
// the canvas has no reset; only the sequencer, the result flag and the config registers are cleared
// a waiting result beat holds the block in its last step until taken
module circle_raster_canvas_core #(
    parameter int MAX_WIDTH  = crcanv_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = crcanv_pkg::DEF_MAX_HEIGHT,
    parameter int FRAC_BITS  = crcanv_pkg::DEF_FRAC_BITS
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // shape_byte, center_x, center_y, radius, paint_char, read_col, read_row
    input  logic [crcanv_pkg::IN_TDATA_W-1:0]      s_tdata,
    // op
    input  logic [crcanv_pkg::OP_W-1:0]            s_tuser,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // status, cell_value
    output logic [crcanv_pkg::OUT_TDATA_W-1:0]     m_tdata,
    input  logic                                   cfg_wr_en,
    input  logic [1:0]                             cfg_index,
    input  logic [crcanv_pkg::SIZE_W-1:0]          cfg_data
);

    localparam int W_W = $clog2(MAX_WIDTH + 1);
    localparam int H_W = $clog2(MAX_HEIGHT + 1);

    logic [crcanv_pkg::SIZE_W-1:0] width_reg;
    logic [crcanv_pkg::SIZE_W-1:0] height_reg;
    logic [crcanv_pkg::CHAR_W-1:0] bg_reg;

    logic [W_W-1:0]                w_used;
    logic [H_W-1:0]                h_used;

    crcanv_pkg::cmd_t              cmd;
    crcanv_pkg::stat_t             stat;

    logic                          out_status;
    logic [crcanv_pkg::CHAR_W-1:0] out_cell;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= crcanv_pkg::RST_CANVAS_WIDTH;
            height_reg <= crcanv_pkg::RST_CANVAS_HEIGHT;
            bg_reg     <= crcanv_pkg::RST_BACKGROUND;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                crcanv_pkg::REG_CANVAS_WIDTH:  width_reg  <= cfg_data;
                crcanv_pkg::REG_CANVAS_HEIGHT: height_reg <= cfg_data;
                crcanv_pkg::REG_BACKGROUND:    bg_reg     <= cfg_data[crcanv_pkg::CHAR_W-1:0];
                default: ;
            endcase
        end
    end

    // zero acts as one, oversize acts as the maximum
    assign w_used = (width_reg == '0) ? W_W'(1)
                  : (32'(width_reg) > MAX_WIDTH) ? W_W'(MAX_WIDTH) : W_W'(width_reg);
    assign h_used = (height_reg == '0) ? H_W'(1)
                  : (32'(height_reg) > MAX_HEIGHT) ? H_W'(MAX_HEIGHT) : H_W'(height_reg);

    crcanv_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_op    (s_tuser),
        .stat     (stat),
        .in_ready (s_tready),
        .cmd      (cmd)
    );

    crcanv_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .FRAC_BITS  (FRAC_BITS),
        .W_W        (W_W),
        .H_W        (H_W)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_op      (s_tuser),
        .in_shape   (s_tdata[7:0]),
        .in_cx      (s_tdata[25:8]),
        .in_cy      (s_tdata[43:26]),
        .in_radius  (s_tdata[60:44]),
        .in_paint   (s_tdata[68:61]),
        .in_col     (s_tdata[76:69]),
        .in_row     (s_tdata[84:77]),
        .bg_char    (bg_reg),
        .w_used     (w_used),
        .h_used     (h_used),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (out_status),
        .out_cell   (out_cell)
    );

    assign m_tdata = {7'd0, out_cell, out_status};

endmodule

// ===== bench/crcanv_checker.sv =====
// scoreboard for the circle raster canvas: shadow canvas, reply prediction and compare
module crcanv_checker (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    input  logic                                  s_tready,
    input  logic [crcanv_pkg::IN_TDATA_W-1:0]     s_tdata,
    input  logic [crcanv_pkg::OP_W-1:0]           s_tuser,
    input  logic                                  m_tvalid,
    input  logic                                  m_tready,
    input  logic [crcanv_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input  logic                                  cfg_wr_en,
    input  logic [1:0]                            cfg_index,
    input  logic [crcanv_pkg::SIZE_W-1:0]         cfg_data,
    output int unsigned                           fail_count,
    output int unsigned                           outstanding
);

    // command beat layout, msb first
    typedef struct packed {
        logic [2:0]                      pad;
        logic [crcanv_pkg::RC_W-1:0]     row;
        logic [crcanv_pkg::RC_W-1:0]     col;
        logic [crcanv_pkg::CHAR_W-1:0]   paint;
        logic [crcanv_pkg::RADIUS_W-1:0] radius;
        logic [crcanv_pkg::CENTER_W-1:0] cy;
        logic [crcanv_pkg::CENTER_W-1:0] cx;
        logic [crcanv_pkg::CHAR_W-1:0]   shape;
    } cmd_fields_t;

    typedef struct packed {
        logic [crcanv_pkg::CHAR_W-1:0] cell_value;
        logic                          status;
    } reply_t;

    logic [crcanv_pkg::CHAR_W-1:0] canvas_shadow
        [0:crcanv_pkg::DEF_MAX_WIDTH*crcanv_pkg::DEF_MAX_HEIGHT-1];
    logic [crcanv_pkg::SIZE_W-1:0] width_reg;
    logic [crcanv_pkg::SIZE_W-1:0] height_reg;
    logic [crcanv_pkg::CHAR_W-1:0] bg_reg;
    reply_t                        pending_replies [$];
    int unsigned                   mismatches = 0;

    function automatic int unsigned clamp_size(logic [crcanv_pkg::SIZE_W-1:0] v,
                                               int unsigned lim);
        if (v == '0)
            return 1;
        if (32'(v) > lim)
            return lim;
        return 32'(v);
    endfunction

    // applies one command to the shadow canvas and returns the reply it owes
    function automatic reply_t rasterize_command(logic [crcanv_pkg::OP_W-1:0] op,
                                                 cmd_fields_t c);
        reply_t      rep;
        int unsigned w;
        int unsigned h;
        int unsigned x;
        int unsigned y;
        longint      one;
        longint      cx;
        longint      cy;
        longint      r;
        longint      outer;
        longint      inner;
        longint      dx;
        longint      dy;
        longint      dy2;
        longint      d2;
        bit          inner_any;
        bit          outline;
        rep = '0;
        w   = clamp_size(width_reg, crcanv_pkg::DEF_MAX_WIDTH);
        h   = clamp_size(height_reg, crcanv_pkg::DEF_MAX_HEIGHT);
        one = longint'(1) << crcanv_pkg::DEF_FRAC_BITS;
        case (op)
            crcanv_pkg::OP_CLEAR:
                for (y = 0; y < h; y++)
                    for (x = 0; x < w; x++)
                        canvas_shadow[y*crcanv_pkg::DEF_MAX_WIDTH + x] = bg_reg;
            crcanv_pkg::OP_DRAW:
                if (c.radius == '0 || (c.shape != crcanv_pkg::SHAPE_DISC
                                       && c.shape != crcanv_pkg::SHAPE_OUTLINE)) begin
                    rep.status = 1'b1;
                end
                else begin
                    cx        = longint'($signed(c.cx));
                    cy        = longint'($signed(c.cy));
                    r         = longint'(c.radius);
                    outer     = r * r;
                    inner_any = (r >= one);
                    inner     = inner_any ? (r - one) * (r - one) : longint'(0);
                    outline   = (c.shape == crcanv_pkg::SHAPE_OUTLINE);
                    for (y = 0; y < h; y++) begin
                        dy  = (longint'(y) << crcanv_pkg::DEF_FRAC_BITS) - cy;
                        dy2 = dy * dy;
                        for (x = 0; x < w; x++) begin
                            dx = (longint'(x) << crcanv_pkg::DEF_FRAC_BITS) - cx;
                            d2 = dy2 + dx * dx;
                            // outline keeps only the ring between r-1 and r
                            if (d2 <= outer && !(outline && inner_any && d2 <= inner))
                                canvas_shadow[y*crcanv_pkg::DEF_MAX_WIDTH + x] = c.paint;
                        end
                    end
                end
            crcanv_pkg::OP_READ:
                if (32'(c.col) < w && 32'(c.row) < h)
                    rep.cell_value = canvas_shadow[int'(c.row)*crcanv_pkg::DEF_MAX_WIDTH
                                                   + int'(c.col)];
            default: ;
        endcase
        return rep;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        reply_t want;
        reply_t got;
        if (!rst_n) begin
            width_reg  = crcanv_pkg::RST_CANVAS_WIDTH;
            height_reg = crcanv_pkg::RST_CANVAS_HEIGHT;
            bg_reg     = crcanv_pkg::RST_BACKGROUND;
            pending_replies.delete();
        end
        else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    crcanv_pkg::REG_CANVAS_WIDTH:  width_reg  = cfg_data;
                    crcanv_pkg::REG_CANVAS_HEIGHT: height_reg = cfg_data;
                    crcanv_pkg::REG_BACKGROUND:    bg_reg     = cfg_data[crcanv_pkg::CHAR_W-1:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got = reply_t'(m_tdata[crcanv_pkg::CHAR_W:0]);
                if (pending_replies.size() == 0) begin
                    $error("reply beat with no command waiting: status %0d cell_value 0x%02h",
                           got.status, got.cell_value);
                    mismatches++;
                end
                else begin
                    want = pending_replies.pop_front();
                    if (got.status !== want.status) begin
                        $error("status mismatch: expected %0d, got %0d", want.status, got.status);
                        mismatches++;
                    end
                    if (got.cell_value !== want.cell_value) begin
                        $error("cell_value mismatch: expected 0x%02h, got 0x%02h",
                               want.cell_value, got.cell_value);
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                pending_replies.push_back(rasterize_command(s_tuser, cmd_fields_t'(s_tdata)));
        end
        fail_count  <= mismatches;
        outstanding <= pending_replies.size();
    end

endmodule

// ===== bench/tb_circle_raster_canvas_core.sv =====
// testbench top for circle_raster_canvas_core: clock, reset, command stimulus and verdict
module tb_circle_raster_canvas_core;

    localparam int OPW = crcanv_pkg::OP_W;
    localparam int CHW = crcanv_pkg::CHAR_W;
    localparam int CW  = crcanv_pkg::CENTER_W;
    localparam int RW  = crcanv_pkg::RADIUS_W;
    localparam int RCW = crcanv_pkg::RC_W;
    localparam int SW  = crcanv_pkg::SIZE_W;

    localparam logic [OPW-1:0] OP_UNUSED   = 2'd3;
    localparam logic [1:0]     REG_NONE    = 2'd3;
    localparam int             ONE         = 1 << crcanv_pkg::DEF_FRAC_BITS;
    localparam int unsigned    CYCLE_LIMIT = 2_000_000;
    localparam int             HOLD_BEAT   = 45;
    localparam int             HOLD_CYCLES = 400;

    logic                                  clk;
    logic                                  rst_n     = 1'b0;
    logic                                  s_tvalid  = 1'b0;
    logic                                  s_tready;
    logic [crcanv_pkg::IN_TDATA_W-1:0]     s_tdata   = '0;
    logic [OPW-1:0]                        s_tuser   = crcanv_pkg::OP_CLEAR;
    logic                                  m_tvalid;
    logic                                  m_tready  = 1'b0;
    logic [crcanv_pkg::OUT_TDATA_W-1:0]    m_tdata;
    logic                                  cfg_wr_en = 1'b0;
    logic [1:0]                            cfg_index = crcanv_pkg::REG_CANVAS_WIDTH;
    logic [SW-1:0]                         cfg_data  = '0;

    int unsigned fail_count;
    int unsigned outstanding;
    int unsigned cycle_count = 0;

    // effective canvas size as the sender sees it
    int unsigned cur_w = crcanv_pkg::DEF_MAX_WIDTH;
    int unsigned cur_h = crcanv_pkg::DEF_MAX_HEIGHT;
    int          send_run = 0;

    circle_raster_canvas_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    crcanv_checker scoreboard (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // random gap, with occasional back-to-back runs
    function automatic int pick_gap(inout int run_left);
        if (run_left > 0) begin
            run_left--;
            return 0;
        end
        if ($urandom_range(0, 7) == 0) begin
            run_left = $urandom_range(8, 16);
            return 0;
        end
        return $urandom_range(0, 10);
    endfunction

    task automatic send_cmd(logic [OPW-1:0] op, logic [CHW-1:0] shape,
                            logic [CW-1:0] cx, logic [CW-1:0] cy,
                            logic [RW-1:0] radius, logic [CHW-1:0] paint,
                            logic [RCW-1:0] col, logic [RCW-1:0] row);
        int gap;
        gap = pick_gap(send_run);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {3'b000, row, col, paint, radius, cy, cx, shape};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    task automatic draw(logic [CHW-1:0] shape, logic [CW-1:0] cx,
                        logic [CW-1:0] cy, logic [RW-1:0] radius,
                        logic [CHW-1:0] paint);
        send_cmd(crcanv_pkg::OP_DRAW, shape, cx, cy, radius, paint,
                 RCW'($urandom), RCW'($urandom));
    endtask

    task automatic read_cell(logic [RCW-1:0] col, logic [RCW-1:0] row);
        send_cmd(crcanv_pkg::OP_READ, CHW'($urandom), CW'($urandom), CW'($urandom),
                 RW'($urandom), CHW'($urandom), col, row);
    endtask

    task automatic clear_canvas();
        send_cmd(crcanv_pkg::OP_CLEAR, CHW'($urandom), CW'($urandom), CW'($urandom),
                 RW'($urandom), CHW'($urandom), RCW'($urandom), RCW'($urandom));
    endtask

    // hold the sender until every reply is back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic configure(logic [SW-1:0] w, logic [SW-1:0] h, logic [CHW-1:0] bg);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_index <= crcanv_pkg::REG_CANVAS_WIDTH;
        cfg_data  <= w;
        @(posedge clk);
        cfg_index <= crcanv_pkg::REG_CANVAS_HEIGHT;
        cfg_data  <= h;
        @(posedge clk);
        cfg_index <= crcanv_pkg::REG_BACKGROUND;
        cfg_data  <= {1'b0, bg};
        @(posedge clk);
        // spare index must leave every register alone
        cfg_index <= REG_NONE;
        cfg_data  <= SW'($urandom);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        repeat (4) @(posedge clk);
        cur_w = (w == '0) ? 1
              : (int'(w) > crcanv_pkg::DEF_MAX_WIDTH) ? crcanv_pkg::DEF_MAX_WIDTH : int'(w);
        cur_h = (h == '0) ? 1
              : (int'(h) > crcanv_pkg::DEF_MAX_HEIGHT) ? crcanv_pkg::DEF_MAX_HEIGHT : int'(h);
    endtask

    task automatic random_cmd();
        int             p;
        int             sel;
        int unsigned    span;
        logic [OPW-1:0] op;
        logic [CHW-1:0] shape;
        logic [CHW-1:0] paint;
        logic [CW-1:0]  cx;
        logic [CW-1:0]  cy;
        logic [RW-1:0]  radius;
        logic [RCW-1:0] col;
        logic [RCW-1:0] row;
        shape  = CHW'($urandom);
        paint  = CHW'($urandom);
        cx     = CW'($urandom);
        cy     = CW'($urandom);
        radius = RW'($urandom);
        col    = RCW'($urandom);
        row    = RCW'($urandom);
        p      = $urandom_range(0, 99);
        if (p < 8)
            op = crcanv_pkg::OP_CLEAR;
        else if (p < 50)
            op = crcanv_pkg::OP_DRAW;
        else if (p < 95)
            op = crcanv_pkg::OP_READ;
        else
            op = OP_UNUSED;
        if (op == crcanv_pkg::OP_DRAW) begin
            sel = $urandom_range(0, 99);
            if (sel < 45)
                shape = crcanv_pkg::SHAPE_DISC;
            else if (sel < 85)
                shape = crcanv_pkg::SHAPE_OUTLINE;
            // centre near the canvas, a couple of cells outside allowed
            if ($urandom_range(0, 9) < 7) begin
                cx = CW'(int'($urandom_range(0, (cur_w + 4) * ONE)) - 2 * ONE);
                cy = CW'(int'($urandom_range(0, (cur_h + 4) * ONE)) - 2 * ONE);
            end
            span = (cur_w > cur_h) ? cur_w : cur_h;
            sel  = $urandom_range(0, 9);
            if (sel == 0)
                radius = '0;
            else if (sel < 3)
                radius = RW'($urandom_range(1, ONE - 1));
            else if (sel < 8)
                radius = RW'($urandom_range(ONE, span * ONE));
        end
        else if (op == crcanv_pkg::OP_READ && $urandom_range(0, 9) < 8) begin
            col = RCW'($urandom_range(0, cur_w - 1));
            row = RCW'($urandom_range(0, cur_h - 1));
        end
        send_cmd(op, shape, cx, cy, radius, paint, col, row);
    endtask

    task automatic random_phase(logic [SW-1:0] w, logic [SW-1:0] h,
                                logic [CHW-1:0] bg, int n);
        configure(w, h, bg);
        // every cell in use is written before any read
        clear_canvas();
        repeat (n - 1) random_cmd();
    endtask

    // result side: random stalls plus one long hold to back the block up
    initial begin
        int gap;
        int run_left;
        int beats;
        run_left = 0;
        beats    = 0;
        forever begin
            gap = pick_gap(run_left);
            if (beats == HOLD_BEAT)
                gap = HOLD_CYCLES;
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
            beats++;
        end
    end

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // full-size canvas at reset values, disc in the far corner
        clear_canvas();
        draw(crcanv_pkg::SHAPE_DISC, CW'(255 * ONE), CW'(255 * ONE), RW'(2 * ONE), "@");
        read_cell(8'd255, 8'd255);
        read_cell(8'd253, 8'd255);
        read_cell(8'd0, 8'd0);

        configure(9'd12, 9'd10, ".");
        clear_canvas();
        read_cell(8'd0, 8'd0);
        draw(crcanv_pkg::SHAPE_DISC, CW'(5 * ONE + ONE / 2), CW'(4 * ONE + ONE / 4),
             RW'(3 * ONE), "#");
        read_cell(8'd5, 8'd4);
        read_cell(8'd8, 8'd4);
        read_cell(8'd9, 8'd4);
        draw(crcanv_pkg::SHAPE_OUTLINE, CW'(5 * ONE), CW'(5 * ONE), RW'(3 * ONE), "o");
        read_cell(8'd5, 8'd5);
        read_cell(8'd8, 8'd5);
        // outline thinner than one cell paints like a disc
        draw(crcanv_pkg::SHAPE_OUTLINE, CW'(2 * ONE), CW'(2 * ONE), RW'(ONE / 2), "x");
        read_cell(8'd2, 8'd2);
        // rejected draws: zero radius and bad shape bytes
        draw(crcanv_pkg::SHAPE_DISC, CW'(3 * ONE), CW'(3 * ONE), '0, "z");
        draw("X", CW'(3 * ONE), CW'(3 * ONE), RW'(3 * ONE), "z");
        draw(8'h00, CW'(3 * ONE), CW'(3 * ONE), RW'(3 * ONE), "z");
        draw(8'hFF, CW'(3 * ONE), CW'(3 * ONE), RW'(3 * ONE), "z");
        // extreme centres and the largest radius
        draw(crcanv_pkg::SHAPE_DISC, 18'h20000, 18'h1FFFF, 17'h1FFFF, 8'h00);
        draw(crcanv_pkg::SHAPE_OUTLINE, 18'h1FFFF, 18'h20000, 17'h1FFFF, 8'hFF);
        read_cell(8'd11, 8'd9);
        read_cell(8'd255, 8'd255);
        read_cell(8'd12, 8'd0);
        read_cell(8'd0, 8'd10);
        send_cmd(OP_UNUSED, 8'hFF, 18'h3FFFF, 18'h3FFFF, 17'h1FFFF, 8'hFF, 8'hFF, 8'hFF);
        clear_canvas();
        read_cell(8'd3, 8'd3);

        random_phase(9'd16, 9'd12, CHW'($urandom), 25);
        random_phase(9'd0, 9'd0, 8'h00, 10);
        random_phase(9'd511, 9'd3, 8'hFF, 10);
        random_phase(9'd2, 9'd511, CHW'($urandom), 10);
        random_phase(SW'($urandom_range(1, 20)), SW'($urandom_range(1, 20)),
                     CHW'($urandom), 17);

        drain();
        repeat (16) @(posedge clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
